@@ src/poly_voice_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// poly_voice_allocator assertion macros
// shared property forms for the allocator checker
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PVA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PVA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// pva_pkg
// types, sizes and helper functions of the polyphonic voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

  // sizing
  localparam int NUM_VOICES = 16;
  localparam int TIME_BITS  = 32;
  localparam int NUM_CHANS  = 16;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CHAN_W     = 4;
  localparam int NOTE_W     = 7;
  localparam int VAL_W      = 16;
  localparam int UVAL_W     = 15;

  // Q1.14 limits
  localparam logic signed [VAL_W-1:0] Q_ONE_S = 16'sd16384;
  localparam logic signed [VAL_W-1:0] Q_NEG_S = -16'sd16384;
  localparam logic signed [VAL_W-1:0] Q_ZERO_S = 16'sd0;

  typedef logic [VIDX_W-1:0]    vidx_t;
  typedef logic [TIME_BITS-1:0] vtime_t;
  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [NOTE_W-1:0]    note_t;

  // event codes
  typedef enum logic [2:0] {
    REQ_NOTE_ON    = 3'd0,
    REQ_NOTE_OFF   = 3'd1,
    REQ_PITCH_BEND = 3'd2,
    REQ_PRESSURE   = 3'd3,
    REQ_TIMBRE     = 3'd4,
    REQ_VOICE_DONE = 3'd5,
    REQ_SUSTAIN    = 3'd6
  } req_t;

  // allocation kinds
  typedef enum logic [1:0] {
    KIND_FREE      = 2'd0,
    KIND_RELEASING = 2'd1,
    KIND_STOLEN    = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_t;

  // voice table write operations
  typedef enum logic [1:0] {
    VW_NONE,
    VW_ALLOC,
    VW_RELEASE,
    VW_FREE
  } voice_op_t;

  typedef struct packed {
    voice_op_t op;
    vidx_t     idx;
    chan_t     chan;
    note_t     note;
    vtime_t    start;
  } voice_wr_t;

  typedef struct packed {
    logic   active;
    logic   releasing;
    chan_t  chan;
    note_t  note;
    vtime_t start;
  } voice_entry_t;

  // channel controller write operations
  typedef enum logic [1:0] {
    CW_NONE,
    CW_BEND,
    CW_PRESSURE,
    CW_TIMBRE
  } ctrl_op_t;

  typedef struct packed {
    ctrl_op_t                op;
    chan_t                   chan;
    logic signed [VAL_W-1:0] value;
  } ctrl_wr_t;

  // outcome of one voice table scan
  typedef struct packed {
    logic  found;
    kind_t kind;
    vidx_t idx;
  } scan_res_t;

  // clamp to [0, 1.0]
  function automatic logic signed [VAL_W-1:0] clamp_unipolar(
    input logic signed [VAL_W-1:0] v
  );
    logic signed [VAL_W-1:0] r;
    r = v;
    if (v < Q_ZERO_S) r = Q_ZERO_S;
    else if (v > Q_ONE_S) r = Q_ONE_S;
    return r;
  endfunction

  // clamp to [-1.0, 1.0]
  function automatic logic signed [VAL_W-1:0] clamp_bipolar(
    input logic signed [VAL_W-1:0] v
  );
    logic signed [VAL_W-1:0] r;
    r = v;
    if (v < Q_NEG_S) r = Q_NEG_S;
    else if (v > Q_ONE_S) r = Q_ONE_S;
    return r;
  endfunction

endpackage

@@ src/poly_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// poly_voice_allocator
// polyphonic voice allocator with stealing and per-channel controllers
// ----------------------------------------------------------------------------
// Events enter on the in_ channel (valid/ready); each gives exactly one result
// on the out_ channel (valid/ready).
// Note-on and note-off walk the voice table one voice per cycle through a
// single time comparator: the sequencer accepts the event in idle, scans
// every voice, applies the result, then loads the output register once it
// is free; out_valid is set by that load.
// Bend, pressure, timbre, voice-done and ignored codes skip the scan and go
// from idle straight to apply, then to the output load.
// The table scan sets the rate for note events.
// in_ready is high only while the sequencer is idle; one event at a time.
// The result sits in an output register; if the receiver stalls, it waits
// there, one more event is taken and held finished in the sequencer, and
// after that no event is taken until the pending result is transferred.
// Reset (rst_n low, synchronous) frees all voices, zeroes every channel
// controller and drops out_valid.
// ----------------------------------------------------------------------------
module poly_voice_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [3:0]         in_chan,
  input  logic [6:0]         in_note_num,
  input  logic signed [15:0] in_ctrl_value,
  input  logic [31:0]        in_event_time,
  input  logic [3:0]         in_done_voice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_voice_index,
  output logic               out_voice_found,
  output logic [1:0]         out_alloc_kind,
  output logic signed [15:0] out_applied_value,
  output logic signed [15:0] out_chan_bend,
  output logic [14:0]        out_chan_pressure,
  output logic [14:0]        out_chan_timbre
);
  import pva_pkg::*;

  state_t state_r, state_nxt;
  vidx_t  scan_idx_r, scan_idx_nxt;

  // latched event
  logic [2:0]              req_type_r;
  chan_t                   req_chan_r;
  note_t                   req_note_r;
  logic signed [VAL_W-1:0] req_val_r;
  vtime_t                  req_start_r;
  logic [3:0]              req_dv_r;

  // pending result
  logic [3:0]              res_idx_r,     res_idx_nxt;
  logic                    res_found_r,   res_found_nxt;
  kind_t                   res_kind_r,    res_kind_nxt;
  logic signed [VAL_W-1:0] res_applied_r, res_applied_nxt;

  logic                    in_xfer;
  logic                    scan_clear;
  logic                    scan_step;
  logic                    out_load;
  logic                    dv_in_range;
  vidx_t                   rd_addr;
  voice_entry_t            rd_entry;
  voice_wr_t               vwr;
  ctrl_wr_t                cwr;
  scan_res_t               scan_res;
  logic signed [VAL_W-1:0] ch_bend;
  logic [UVAL_W-1:0]       ch_pressure;
  logic [UVAL_W-1:0]       ch_timbre;

  logic                    out_valid_r;
  logic [3:0]              out_idx_r;
  logic                    out_found_r;
  kind_t                   out_kind_r;
  logic signed [VAL_W-1:0] out_applied_r;
  logic signed [VAL_W-1:0] out_bend_r;
  logic [UVAL_W-1:0]       out_pressure_r;
  logic [UVAL_W-1:0]       out_timbre_r;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign dv_in_range = ({28'd0, req_dv_r} < 32'(NUM_VOICES));

  pva_voice_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (vwr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  pva_scan_unit u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (scan_clear),
    .step       (scan_step),
    .is_note_on (req_type_r == REQ_NOTE_ON),
    .req_chan   (req_chan_r),
    .req_note   (req_note_r),
    .idx        (scan_idx_r),
    .entry      (rd_entry),
    .res        (scan_res)
  );

  pva_chan_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (cwr),
    .rd_chan  (req_chan_r),
    .bend     (ch_bend),
    .pressure (ch_pressure),
    .timbre   (ch_timbre)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_type_r  <= in_req_type;
      req_chan_r  <= in_chan;
      req_note_r  <= in_note_num;
      req_val_r   <= in_ctrl_value;
      req_start_r <= vtime_t'(in_event_time);
      req_dv_r    <= in_done_voice;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    res_idx_r     <= res_idx_nxt;
    res_found_r   <= res_found_nxt;
    res_kind_r    <= res_kind_nxt;
    res_applied_r <= res_applied_nxt;
  end

  // next state, voice table and channel controller updates
  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    scan_clear      = 1'b0;
    scan_step       = 1'b0;
    out_load        = 1'b0;
    rd_addr         = scan_idx_r;
    vwr.op          = VW_NONE;
    vwr.idx         = scan_res.idx;
    vwr.chan        = req_chan_r;
    vwr.note        = req_note_r;
    vwr.start       = req_start_r;
    cwr.op          = CW_NONE;
    cwr.chan        = req_chan_r;
    cwr.value       = '0;
    res_idx_nxt     = res_idx_r;
    res_found_nxt   = res_found_r;
    res_kind_nxt    = res_kind_r;
    res_applied_nxt = res_applied_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_clear   = 1'b1;
          scan_idx_nxt = '0;
          if (in_req_type == REQ_NOTE_ON || in_req_type == REQ_NOTE_OFF) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end

      ST_SCAN: begin
        scan_step = 1'b1;
        if (scan_idx_r == vidx_t'(NUM_VOICES - 1)) begin
          state_nxt = ST_APPLY;
        end else begin
          scan_idx_nxt = scan_idx_r + vidx_t'(1);
        end
      end

      ST_APPLY: begin
        rd_addr         = vidx_t'(req_dv_r);
        res_idx_nxt     = '0;
        res_found_nxt   = 1'b0;
        res_kind_nxt    = KIND_NONE;
        res_applied_nxt = '0;
        unique case (req_type_r)
          REQ_NOTE_ON: begin
            vwr.op          = VW_ALLOC;
            res_idx_nxt     = 4'(scan_res.idx);
            res_found_nxt   = 1'b1;
            res_kind_nxt    = scan_res.kind;
            res_applied_nxt = clamp_unipolar(req_val_r);
          end
          REQ_NOTE_OFF: begin
            if (scan_res.found) begin
              vwr.op = VW_RELEASE;
            end
            res_idx_nxt   = 4'(scan_res.idx);
            res_found_nxt = scan_res.found;
          end
          REQ_PITCH_BEND: begin
            cwr.op          = CW_BEND;
            cwr.value       = clamp_bipolar(req_val_r);
            res_applied_nxt = clamp_bipolar(req_val_r);
          end
          REQ_PRESSURE: begin
            cwr.op          = CW_PRESSURE;
            cwr.value       = clamp_unipolar(req_val_r);
            res_applied_nxt = clamp_unipolar(req_val_r);
          end
          REQ_TIMBRE: begin
            cwr.op          = CW_TIMBRE;
            cwr.value       = clamp_unipolar(req_val_r);
            res_applied_nxt = clamp_unipolar(req_val_r);
          end
          REQ_VOICE_DONE: begin
            res_idx_nxt = req_dv_r;
            if (dv_in_range && rd_entry.active) begin
              vwr.op        = VW_FREE;
              vwr.idx       = vidx_t'(req_dv_r);
              res_found_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r      <= res_idx_r;
      out_found_r    <= res_found_r;
      out_kind_r     <= res_kind_r;
      out_applied_r  <= res_applied_r;
      out_bend_r     <= ch_bend;
      out_pressure_r <= ch_pressure;
      out_timbre_r   <= ch_timbre;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_voice_index   = out_idx_r;
  assign out_voice_found   = out_found_r;
  assign out_alloc_kind    = out_kind_r;
  assign out_applied_value = out_applied_r;
  assign out_chan_bend     = out_bend_r;
  assign out_chan_pressure = out_pressure_r;
  assign out_chan_timbre   = out_timbre_r;

endmodule

@@ src/pva_voice_table.sv @@
// ----------------------------------------------------------------------------
// pva_voice_table
// per-voice flags, channel, note and start time with one read port
// ----------------------------------------------------------------------------
module pva_voice_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pva_pkg::voice_wr_t    wr,
  input  pva_pkg::vidx_t        rd_addr,
  output pva_pkg::voice_entry_t rd_entry
);
  import pva_pkg::*;

  logic [NUM_VOICES-1:0] active_r;
  logic [NUM_VOICES-1:0] releasing_r;
  chan_t                 chan_r  [NUM_VOICES];
  note_t                 note_r  [NUM_VOICES];
  vtime_t                start_r [NUM_VOICES];

  // flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      releasing_r <= '0;
    end else begin
      unique case (wr.op)
        VW_ALLOC: begin
          active_r[wr.idx]    <= 1'b1;
          releasing_r[wr.idx] <= 1'b0;
        end
        VW_RELEASE: begin
          releasing_r[wr.idx] <= 1'b1;
        end
        VW_FREE: begin
          active_r[wr.idx]    <= 1'b0;
          releasing_r[wr.idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // voice payload, written only on allocation
  always_ff @(posedge clk) begin
    if (wr.op == VW_ALLOC) begin
      chan_r[wr.idx]  <= wr.chan;
      note_r[wr.idx]  <= wr.note;
      start_r[wr.idx] <= wr.start;
    end
  end

  // read port
  always_comb begin
    rd_entry.active    = active_r[rd_addr];
    rd_entry.releasing = releasing_r[rd_addr];
    rd_entry.chan      = chan_r[rd_addr];
    rd_entry.note      = note_r[rd_addr];
    rd_entry.start     = start_r[rd_addr];
  end

endmodule

@@ src/pva_scan_unit.sv @@
// ----------------------------------------------------------------------------
// pva_scan_unit
// walks the voice table one entry a cycle with one shared time comparator
// ----------------------------------------------------------------------------
module pva_scan_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  step,
  input  logic                  is_note_on,
  input  pva_pkg::chan_t        req_chan,
  input  pva_pkg::note_t        req_note,
  input  pva_pkg::vidx_t        idx,
  input  pva_pkg::voice_entry_t entry,
  output pva_pkg::scan_res_t    res
);
  import pva_pkg::*;

  logic   free_found_r, free_found_nxt;
  vidx_t  free_idx_r,   free_idx_nxt;
  logic   rel_found_r,  rel_found_nxt;
  vidx_t  rel_idx_r,    rel_idx_nxt;
  logic   best_found_r, best_found_nxt;
  vidx_t  best_idx_r,   best_idx_nxt;
  vtime_t best_start_r, best_start_nxt;

  vtime_t cmp_a;
  vtime_t cmp_b;
  logic   cmp_lt;
  logic   candidate;

  // shared comparator: older-than for note-on, newer-than for note-off
  always_comb begin
    cmp_a  = is_note_on ? entry.start : best_start_r;
    cmp_b  = is_note_on ? best_start_r : entry.start;
    cmp_lt = cmp_a < cmp_b;
  end

  // candidate voice for the time search
  always_comb begin
    candidate = is_note_on ||
                (entry.active && (entry.chan == req_chan) && (entry.note == req_note));
  end

  // running bests
  always_comb begin
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    rel_found_nxt  = rel_found_r;
    rel_idx_nxt    = rel_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    if (clear) begin
      free_found_nxt = 1'b0;
      rel_found_nxt  = 1'b0;
      best_found_nxt = 1'b0;
    end else if (step) begin
      if (!entry.active && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx;
      end
      if (entry.releasing && !rel_found_r) begin
        rel_found_nxt = 1'b1;
        rel_idx_nxt   = idx;
      end
      if (candidate && (!best_found_r || cmp_lt)) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = idx;
        best_start_nxt = entry.start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_found_r <= 1'b0;
      rel_found_r  <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      free_found_r <= free_found_nxt;
      rel_found_r  <= rel_found_nxt;
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r   <= free_idx_nxt;
    rel_idx_r    <= rel_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
  end

  // priority: free voice, then releasing voice, then time search winner
  always_comb begin
    priority if (is_note_on && free_found_r) begin
      res.found = 1'b1;
      res.kind  = KIND_FREE;
      res.idx   = free_idx_r;
    end else if (is_note_on && rel_found_r) begin
      res.found = 1'b1;
      res.kind  = KIND_RELEASING;
      res.idx   = rel_idx_r;
    end else if (is_note_on) begin
      res.found = 1'b1;
      res.kind  = KIND_STOLEN;
      res.idx   = best_idx_r;
    end else begin
      res.found = best_found_r;
      res.kind  = KIND_NONE;
      res.idx   = best_found_r ? best_idx_r : '0;
    end
  end

endmodule

@@ src/pva_chan_ctrl.sv @@
// ----------------------------------------------------------------------------
// pva_chan_ctrl
// per-channel bend, pressure and timbre registers
// ----------------------------------------------------------------------------
module pva_chan_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pva_pkg::ctrl_wr_t                    wr,
  input  pva_pkg::chan_t                       rd_chan,
  output logic signed [pva_pkg::VAL_W-1:0]     bend,
  output logic        [pva_pkg::UVAL_W-1:0]    pressure,
  output logic        [pva_pkg::UVAL_W-1:0]    timbre
);
  import pva_pkg::*;

  logic signed [VAL_W-1:0] bend_r     [NUM_CHANS];
  logic        [UVAL_W-1:0] pressure_r [NUM_CHANS];
  logic        [UVAL_W-1:0] timbre_r   [NUM_CHANS];

  // controller updates, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANS; i++) begin
        bend_r[i]     <= '0;
        pressure_r[i] <= '0;
        timbre_r[i]   <= '0;
      end
    end else begin
      unique case (wr.op)
        CW_BEND:     bend_r[wr.chan]     <= wr.value;
        CW_PRESSURE: pressure_r[wr.chan] <= wr.value[UVAL_W-1:0];
        CW_TIMBRE:   timbre_r[wr.chan]   <= wr.value[UVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read port
  assign bend     = bend_r[rd_chan];
  assign pressure = pressure_r[rd_chan];
  assign timbre   = timbre_r[rd_chan];

endmodule

@@ src/pva_checker.sv @@
// ----------------------------------------------------------------------------
// pva_checker
// port-level checks of the voice allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_assert.svh"

module pva_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_voice_index,
  input logic               out_voice_found,
  input logic [1:0]         out_alloc_kind,
  input logic signed [15:0] out_applied_value,
  input logic signed [15:0] out_chan_bend,
  input logic [14:0]        out_chan_pressure,
  input logic [14:0]        out_chan_timbre
);
  import pva_pkg::*;

  // stalled result holds
  `PVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_voice_index) && $stable(out_voice_found) && $stable(out_alloc_kind) && $stable(out_applied_value), "result changed while stalled")

  // one event at a time: busy right after a transfer in
  `PVA_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while an event is in progress")

  // any allocation reports a voice
  `PVA_ASSERT_SAME(a_alloc_found, out_valid && (out_alloc_kind != KIND_NONE), out_voice_found, "allocation without a voice")

  // applied value stays clamped
  `PVA_ASSERT_SAME(a_applied_range, out_valid, (out_applied_value >= Q_NEG_S) && (out_applied_value <= Q_ONE_S), "applied value out of range")

  // channel controllers stay clamped
  `PVA_ASSERT_SAME(a_chan_range, out_valid, (out_chan_bend >= Q_NEG_S) && (out_chan_bend <= Q_ONE_S) && (out_chan_pressure <= 15'd16384) && (out_chan_timbre <= 15'd16384), "channel controller out of range")

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (.*);
